// ===== design/sird_pkg.sv =====
// shared types, constants and helpers for the signed integer to radix digits block
package sird_pkg;

    localparam int MAX_SYMBOLS   = 16;
    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 8;
    localparam int CFG_W         = 64;
    localparam int SYM_TABLE_W   = MAX_SYMBOLS * CHAR_W;
    localparam int DIGIT_W       = $clog2(MAX_SYMBOLS);
    localparam int COUNT_W       = 5;
    localparam int MAX_DIGITS    = VALUE_W;
    localparam int SP_W          = $clog2(MAX_DIGITS + 1);
    localparam int STACK_IDX_W   = $clog2(MAX_DIGITS);
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W     = 2;

    typedef logic [COUNT_W-1:0]     t_count;
    typedef logic [DIGIT_W-1:0]     t_digit;
    typedef logic [CHAR_W-1:0]      t_char;
    typedef logic [SP_W-1:0]        t_sp;
    typedef logic [STEP_W-1:0]      t_step;
    typedef logic [QPTR_W-1:0]      t_qptr;
    typedef logic [QCNT_W-1:0]      t_qcnt;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic [SYM_TABLE_W-1:0] t_sym_table;

    localparam t_char CH_PLUS    = 8'h2B;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_NEWLINE = 8'h0A;

    localparam t_cfg_idx CFG_SYMBOLS_LOW  = 2'd0;
    localparam t_cfg_idx CFG_SYMBOLS_HIGH = 2'd1;
    localparam t_cfg_idx CFG_SYMBOL_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] SYMBOLS_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] SYMBOLS_HIGH_RST = 64'h0000000000003938;
    localparam t_count           SYMBOL_COUNT_RST = 5'd10;

    localparam t_step STEP_LAST = t_step'(DIV_STEPS - 1);

    typedef struct packed {
        logic               neg;
        logic               bad;
        logic [VALUE_W-1:0] mag;
    } t_item;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_SIGN,
        BS_DIGIT
    } t_bstate;

    function automatic t_char symbol_at(input t_sym_table tbl, input t_digit idx);
        symbol_at = tbl[{idx, 3'b000} +: CHAR_W];
    endfunction

endpackage

// ===== design/sird_front.sv =====
// front end: input transfer, sign split and base validity check
module sird_front (
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [sird_pkg::VALUE_W-1:0] i_value,
    input  sird_pkg::t_sym_table            i_symbols,
    input  sird_pkg::t_count                i_symbol_count,
    input  logic                            i_q_full,
    output logic                            o_push,
    output sird_pkg::t_item                 o_item
);

    logic [sird_pkg::VALUE_W-1:0] raw;
    logic                         neg;
    logic                         bad;
    sird_pkg::t_char              sa;

    assign raw = $unsigned(i_value);
    assign neg = raw[sird_pkg::VALUE_W-1];

    // invalid base: too few or too many symbols, a sign symbol, or a repeat
    always_comb begin
        bad = (i_symbol_count < sird_pkg::t_count'(2))
           || (i_symbol_count > sird_pkg::t_count'(sird_pkg::MAX_SYMBOLS));
        sa  = '0;
        for (int a = 0; a < sird_pkg::MAX_SYMBOLS; a++) begin
            if (sird_pkg::t_count'(a) < i_symbol_count) begin
                sa = sird_pkg::symbol_at(i_symbols, sird_pkg::t_digit'(a));
                if (sa == sird_pkg::CH_PLUS || sa == sird_pkg::CH_MINUS) begin
                    bad = 1'b1;
                end
                for (int b = a + 1; b < sird_pkg::MAX_SYMBOLS; b++) begin
                    if (sird_pkg::t_count'(b) < i_symbol_count &&
                        sird_pkg::symbol_at(i_symbols, sird_pkg::t_digit'(b)) == sa) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_item.neg = neg;
    assign o_item.bad = bad;
    assign o_item.mag = neg ? (sird_pkg::VALUE_W'(0) - raw) : raw;

endmodule

// ===== design/sird_queue.sv =====
// short queue of classified items between front and back
module sird_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sird_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sird_pkg::t_item o_item
);

    sird_pkg::t_item r_mem [sird_pkg::QUEUE_DEPTH];
    sird_pkg::t_qptr r_wr_ptr;
    sird_pkg::t_qptr r_rd_ptr;
    sird_pkg::t_qcnt r_count;
    sird_pkg::t_qcnt n_count;

    assign o_full  = (r_count == sird_pkg::t_qcnt'(sird_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + sird_pkg::t_qcnt'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - sird_pkg::t_qcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + sird_pkg::t_qptr'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + sird_pkg::t_qptr'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/sird_back.sv =====
// back end: iterative digit extraction, digit stack and character output register
module sird_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  sird_pkg::t_item      i_q_item,
    output logic                 o_pop,
    input  sird_pkg::t_sym_table i_symbols,
    input  sird_pkg::t_count     i_symbol_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sird_pkg::t_char      o_character,
    output logic                 o_last
);

    sird_pkg::t_bstate            r_state;
    sird_pkg::t_bstate            n_state;
    logic                         r_neg;
    logic [sird_pkg::VALUE_W-1:0] r_div;
    logic [sird_pkg::VALUE_W-1:0] n_div;
    sird_pkg::t_digit             r_rem;
    sird_pkg::t_digit             n_rem;
    sird_pkg::t_step              r_step;
    sird_pkg::t_sp                r_sp;
    sird_pkg::t_sp                sp_dec;
    sird_pkg::t_digit             r_stack [sird_pkg::MAX_DIGITS];
    logic                         r_out_valid;
    sird_pkg::t_char              r_out_char;
    logic                         r_out_last;
    logic [sird_pkg::DIGIT_W:0]   trial;

    logic            out_free;
    logic            div_start;
    logic            div_push;
    logic            digit_pop;
    logic            emit;
    sird_pkg::t_char emit_char;
    logic            emit_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign sp_dec   = r_sp - sird_pkg::t_sp'(1);

    // eight restoring division steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_div = r_div;
        trial = '0;
        for (int i = 0; i < sird_pkg::BITS_PER_STEP; i++) begin
            trial = {n_rem, n_div[sird_pkg::VALUE_W-1]};
            n_div = {n_div[sird_pkg::VALUE_W-2:0], 1'b0};
            if (trial >= i_symbol_count) begin
                n_rem    = sird_pkg::t_digit'(trial - i_symbol_count);
                n_div[0] = 1'b1;
            end else begin
                n_rem = trial[sird_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sird_pkg::BS_IDLE: begin
                if (i_q_valid && !i_q_item.bad) begin
                    n_state = sird_pkg::BS_DIV;
                end
            end
            sird_pkg::BS_DIV: begin
                if (r_step == sird_pkg::STEP_LAST && n_div == '0) begin
                    n_state = r_neg ? sird_pkg::BS_SIGN : sird_pkg::BS_DIGIT;
                end
            end
            sird_pkg::BS_SIGN: begin
                if (out_free) begin
                    n_state = sird_pkg::BS_DIGIT;
                end
            end
            sird_pkg::BS_DIGIT: begin
                if (out_free && r_sp == sird_pkg::t_sp'(1)) begin
                    n_state = sird_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = sird_pkg::BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_push  = 1'b0;
        digit_pop = 1'b0;
        emit      = 1'b0;
        emit_char = sird_pkg::CH_NEWLINE;
        emit_last = 1'b0;
        case (r_state)
            sird_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.bad) begin
                        if (out_free) begin
                            o_pop     = 1'b1;
                            emit      = 1'b1;
                            emit_last = 1'b1;
                        end
                    end else begin
                        o_pop     = 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            sird_pkg::BS_DIV: begin
                div_push = (r_step == sird_pkg::STEP_LAST);
            end
            sird_pkg::BS_SIGN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = sird_pkg::CH_MINUS;
                end
            end
            sird_pkg::BS_DIGIT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    digit_pop = 1'b1;
                    emit_char = sird_pkg::symbol_at(i_symbols,
                                    r_stack[sp_dec[sird_pkg::STACK_IDX_W-1:0]]);
                    emit_last = (r_sp == sird_pkg::t_sp'(1));
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sird_pkg::BS_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_start) begin
                r_sp <= '0;
            end else if (div_push) begin
                r_sp <= r_sp + sird_pkg::t_sp'(1);
            end else if (digit_pop) begin
                r_sp <= sp_dec;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg  <= i_q_item.neg;
            r_div  <= i_q_item.mag;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == sird_pkg::BS_DIV) begin
            r_div  <= n_div;
            r_rem  <= div_push ? '0 : n_rem;
            r_step <= r_step + sird_pkg::t_step'(1);
        end
        if (div_push) begin
            r_stack[r_sp[sird_pkg::STACK_IDX_W-1:0]] <= n_rem;
        end
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= sird_pkg::t_sp'(sird_pkg::MAX_DIGITS))
        else $error("digit stack overflow");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sird_pkg::BS_DIV) |-> ({1'b0, r_rem} < i_symbol_count))
        else $error("partial remainder not below radix");

    a_digit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sird_pkg::BS_DIGIT) |-> (r_sp != '0))
        else $error("digit output with empty stack");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sird_pkg::BS_IDLE) |-> (r_sp == '0))
        else $error("stack not drained at end of run");

    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sird_pkg::BS_SIGN) |-> r_neg)
        else $error("sign emitted for non-negative value");
`endif

endmodule

// ===== design/signed_integer_to_radix_digits.sv =====
// top level: configuration registers, front end, item queue and back end
// digit extraction: each digit is a full division of the magnitude by the radix,
// retiring 8 quotient bits a cycle; digits then leave one character a cycle while the
// output is not stalled, and the queue lets new values be taken while one is converted
// invalid base: one newline, passed through the queue and the output register
// reset: synchronous active low, empties the queue and restores the default symbol table
module signed_integer_to_radix_digits (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [sird_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sird_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic [sird_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sird_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [sird_pkg::CFG_W-1:0] r_symbols_low;
    logic [sird_pkg::CFG_W-1:0] r_symbols_high;
    sird_pkg::t_count           r_symbol_count;
    sird_pkg::t_sym_table       symbols;

    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    sird_pkg::t_item front_item;
    sird_pkg::t_item q_item;

    assign symbols = {r_symbols_high, r_symbols_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbols_low  <= sird_pkg::SYMBOLS_LOW_RST;
            r_symbols_high <= sird_pkg::SYMBOLS_HIGH_RST;
            r_symbol_count <= sird_pkg::SYMBOL_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sird_pkg::CFG_SYMBOLS_LOW: begin
                    r_symbols_low <= i_cfg_data;
                end
                sird_pkg::CFG_SYMBOLS_HIGH: begin
                    r_symbols_high <= i_cfg_data;
                end
                sird_pkg::CFG_SYMBOL_COUNT: begin
                    r_symbol_count <= i_cfg_data[sird_pkg::COUNT_W-1:0];
                end
                default: begin
                    r_symbol_count <= r_symbol_count;
                end
            endcase
        end
    end

    sird_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_symbols      (symbols),
        .i_symbol_count (r_symbol_count),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    sird_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    sird_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .i_symbols      (symbols),
        .i_symbol_count (r_symbol_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_character    (o_character),
        .o_last         (o_last)
    );

endmodule

// ===== tb/sv/signed_integer_to_radix_digits_tb.sv =====
// self-checking testbench for the signed integer to radix digits converter
module signed_integer_to_radix_digits_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam sird_pkg::t_cfg_idx CFG_SPARE   = 2'd3;
    localparam int                 CYCLE_LIMIT = 400000;
    localparam int                 RUN_PHASES  = 10;
    localparam int                 PHASE_ITEMS = 15;

    typedef struct packed {
        sird_pkg::t_char ch;
        logic            last;
    } t_emit;

    typedef struct packed {
        logic                         is_cfg;
        sird_pkg::t_cfg_idx           idx;
        logic [sird_pkg::CFG_W-1:0]   data;
        logic [sird_pkg::VALUE_W-1:0] value;
        logic                         typed;
        logic [95:0]                  text;
    } t_stim_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic signed [sird_pkg::VALUE_W-1:0] i_value;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [sird_pkg::CHAR_W-1:0]         o_character;
    logic                                o_last;
    logic                                i_cfg_we;
    logic [sird_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [sird_pkg::CFG_W-1:0]          i_cfg_data;

    logic [sird_pkg::CFG_W-1:0] digit_syms_lo;
    logic [sird_pkg::CFG_W-1:0] digit_syms_hi;
    sird_pkg::t_count           radix_reg;

    t_emit     pending_chars[$];
    t_stim_row stim_rows[$];

    bit idle_on;
    int err_count;
    int items_sent;
    int chars_seen;
    int newline_items;
    int reg_writes;
    int cycle_count;

    signed_integer_to_radix_digits u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic sird_pkg::t_char symbol_of(input int k);
        logic [2*sird_pkg::CFG_W-1:0] tbl;
        tbl = {digit_syms_hi, digit_syms_lo};
        return tbl[8*k +: 8];
    endfunction

    function automatic bit radix_table_ok();
        int n;
        n = radix_reg;
        if (n < 2 || n > sird_pkg::MAX_SYMBOLS) return 1'b0;
        for (int a = 0; a < n; a++) begin
            if (symbol_of(a) == sird_pkg::CH_PLUS || symbol_of(a) == sird_pkg::CH_MINUS)
                return 1'b0;
            for (int b = a + 1; b < n; b++) begin
                if (symbol_of(b) == symbol_of(a)) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // expected characters of one conversion, most significant digit first, or a single newline on a rejected table
    function automatic void predict_digits(input logic [sird_pkg::VALUE_W-1:0] raw);
        logic [sird_pkg::VALUE_W-1:0] mag;
        logic [sird_pkg::VALUE_W-1:0] radix;
        logic [3:0]                   digs[sird_pkg::MAX_DIGITS];
        int                           nd;
        if (!radix_table_ok()) begin
            pending_chars.push_back('{sird_pkg::CH_NEWLINE, 1'b1});
            return;
        end
        radix = sird_pkg::VALUE_W'(radix_reg);
        mag = raw[sird_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
        nd = 0;
        do begin
            digs[nd] = 4'(mag % radix);
            mag = mag / radix;
            nd++;
        end while (mag != 0);
        if (raw[sird_pkg::VALUE_W-1]) pending_chars.push_back('{sird_pkg::CH_MINUS, 1'b0});
        for (int d = nd - 1; d >= 0; d--) begin
            pending_chars.push_back('{symbol_of(digs[d]), d == 0});
        end
    endfunction

    // typed expectation: text string, leading zero bytes are padding
    function automatic void push_text(input logic [95:0] text);
        int top;
        top = 0;
        for (int i = 0; i < 12; i++) begin
            if (text[8*i +: 8] != 8'h00) top = i;
        end
        for (int i = top; i >= 0; i--) begin
            pending_chars.push_back('{text[8*i +: 8], i == 0});
        end
    endfunction

    task automatic row_item(input logic [sird_pkg::VALUE_W-1:0] v, input logic typed,
                            input logic [95:0] text);
        stim_rows.push_back('{1'b0, CFG_SPARE, 64'd0, v, typed, text});
    endtask

    task automatic row_cfg(input sird_pkg::t_cfg_idx idx,
                           input logic [sird_pkg::CFG_W-1:0] data);
        stim_rows.push_back('{1'b1, idx, data, 32'd0, 1'b0, 96'd0});
    endtask

    task automatic write_reg(input sird_pkg::t_cfg_idx idx,
                             input logic [sird_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sird_pkg::CFG_SYMBOLS_LOW:  digit_syms_lo = data;
            sird_pkg::CFG_SYMBOLS_HIGH: digit_syms_hi = data;
            sird_pkg::CFG_SYMBOL_COUNT: radix_reg = data[sird_pkg::COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic convert_value(input logic [sird_pkg::VALUE_W-1:0] v, input logic typed,
                                 input logic [95:0] text);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        if (!radix_table_ok()) newline_items++;
        if (typed) push_text(text);
        else predict_digits(v);
        items_sent++;
    endtask

    // sender holds off until every expected character has arrived
    task automatic drain_outputs();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(0, 99) < 20);
    end

    always @(posedge i_clk) begin
        t_emit want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("signed_integer_to_radix_digits test failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer %02h last %0b",
                                        o_character, o_last));
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch)
                    flag_mismatch($sformatf("character %02h, expected %02h",
                                            o_character, want.ch));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("last %0b, expected %0b on %02h",
                                            o_last, want.last, want.ch));
            end
        end
    end

    initial begin
        logic [2*sird_pkg::CFG_W-1:0]        tbl;
        logic [sird_pkg::CFG_W-1:0]          cnt_word;
        logic signed [sird_pkg::VALUE_W-1:0] v;
        logic [7:0]                          sym;
        bit                                  clash;
        int                                  n;
        int                                  a;
        int                                  b;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = sird_pkg::CFG_SYMBOLS_LOW;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        digit_syms_lo = sird_pkg::SYMBOLS_LOW_RST;
        digit_syms_hi = sird_pkg::SYMBOLS_HIGH_RST;
        radix_reg     = sird_pkg::SYMBOL_COUNT_RST;

        // reset table, decimal
        row_item(32'd0, 1'b1, "0");
        row_item(32'h7FFFFFFF, 1'b1, "2147483647");
        row_item(32'h80000000, 1'b1, "-2147483648");
        row_item(32'hFFFFFFFF, 1'b1, "-1");
        row_item(32'd1000, 1'b0, "");
        // hexadecimal
        row_cfg(sird_pkg::CFG_SYMBOLS_LOW, "76543210");
        row_cfg(sird_pkg::CFG_SYMBOLS_HIGH, "FEDCBA98");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd16);
        row_item(32'h80000000, 1'b1, "-80000000");
        row_item(32'h7FFFFFFF, 1'b1, "7FFFFFFF");
        row_item(32'd255, 1'b0, "");
        row_item(-32'sd16, 1'b1, "-10");
        // binary, longest runs
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd2);
        row_item(32'h80000000, 1'b0, "");
        row_item(32'h7FFFFFFF, 1'b0, "");
        row_item(32'hFFFFFFFF, 1'b1, "-1");
        row_item(32'd5, 1'b1, "101");
        // zero byte used as a digit symbol
        row_cfg(sird_pkg::CFG_SYMBOLS_LOW, 64'h0000_0000_0000_FF00);
        row_item(32'd6, 1'b0, "");
        row_item(-32'sd3, 1'b0, "");
        // rejected tables: too few symbols, too many, signs, repeats
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd0);
        row_item(32'd5, 1'b1, "\n");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd1);
        row_item(32'd5, 1'b1, "\n");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd17);
        row_item(-32'sd7, 1'b1, "\n");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        row_item(32'd0, 1'b1, "\n");
        row_cfg(sird_pkg::CFG_SYMBOLS_LOW, "7654321-");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd10);
        row_item(32'd42, 1'b1, "\n");
        row_cfg(sird_pkg::CFG_SYMBOLS_LOW, "76543210");
        row_cfg(sird_pkg::CFG_SYMBOLS_HIGH, "+EDCBA98");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd16);
        row_item(32'd42, 1'b1, "\n");
        row_cfg(sird_pkg::CFG_SYMBOLS_HIGH, "0EDCBA98");
        row_item(32'd42, 1'b1, "\n");
        // sign symbol beyond the radix is ignored
        row_cfg(sird_pkg::CFG_SYMBOLS_HIGH, "FED+BA98");
        row_cfg(sird_pkg::CFG_SYMBOL_COUNT, 64'd10);
        row_item(-32'sd123, 1'b0, "");
        // write to the spare index changes nothing
        row_cfg(CFG_SPARE, 64'd0);
        row_item(32'd77, 1'b0, "");

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].is_cfg) begin
                drain_outputs();
                write_reg(stim_rows[r].idx, stim_rows[r].data);
            end else begin
                convert_value(stim_rows[r].value, stim_rows[r].typed, stim_rows[r].text);
            end
        end

        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            tbl = {$urandom, $urandom, $urandom, $urandom};
            if (ph == 3) begin
                n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            end else begin
                n = (ph == 0) ? 16 : (ph == 1) ? 2 : $urandom_range(2, 16);
                for (int k = 0; k < n; k++) begin
                    do begin
                        sym = 8'($urandom_range(0, 255));
                        clash = (sym == sird_pkg::CH_PLUS) || (sym == sird_pkg::CH_MINUS);
                        for (int j = 0; j < k; j++) begin
                            if (tbl[8*j +: 8] == sym) clash = 1'b1;
                        end
                    end while (clash);
                    tbl[8*k +: 8] = sym;
                end
                // spoil one symbol in use
                if (ph == 7) begin
                    a = $urandom_range(0, n - 1);
                    b = (a + $urandom_range(1, n - 1)) % n;
                    if ($urandom_range(0, 1))
                        tbl[8*a +: 8] = $urandom_range(0, 1) ? sird_pkg::CH_PLUS
                                                             : sird_pkg::CH_MINUS;
                    else
                        tbl[8*a +: 8] = tbl[8*b +: 8];
                end
            end
            cnt_word = {$urandom, $urandom};
            cnt_word[sird_pkg::COUNT_W-1:0] = sird_pkg::COUNT_W'(n);
            drain_outputs();
            write_reg(sird_pkg::CFG_SYMBOLS_LOW, tbl[sird_pkg::CFG_W-1:0]);
            write_reg(sird_pkg::CFG_SYMBOLS_HIGH, tbl[2*sird_pkg::CFG_W-1:sird_pkg::CFG_W]);
            write_reg(sird_pkg::CFG_SYMBOL_COUNT, cnt_word);
            idle_on = !(ph == 5 || ph == 6);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: v = 32'h80000000;
                            1: v = 32'h7FFFFFFF;
                            2: v = 32'd0;
                            default: v = -32'sd1;
                        endcase
                    end
                    1, 2: v = $urandom_range(0, 100) - 50;
                    3, 4, 5: begin
                        v = $urandom >> $urandom_range(0, 31);
                        if ($urandom_range(0, 1)) v = -v;
                    end
                    default: v = $urandom;
                endcase
                convert_value(v, 1'b0, 96'd0);
            end
        end

        idle_on = 1'b1;
        drain_outputs();
        repeat (20) @(posedge i_clk);

        $display("converted %0d values through %0d register writes, %0d on a rejected table",
                 items_sent, reg_writes, newline_items);
        $display("%0d characters checked, %0d mismatches", chars_seen, err_count);
        if (err_count == 0) begin
            $display("signed_integer_to_radix_digits test passed");
        end else begin
            $display("signed_integer_to_radix_digits test failed");
        end
        $finish;
    end

endmodule
